/* rtl/stkthr_pkg.sv */
// Package for the threshold-remove record stack: record and result types,
// operation and status codes. No dependencies.
`default_nettype none

package stkthr_pkg;

    // Operation codes carried on the input channel
    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_POP    = 3'd1;
    localparam logic [2:0] OP_PEEK   = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_DRAIN  = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic        [31:0] name;
        logic        [7:0]  kind;
        logic signed [31:0] value;
    } t_rec;

    typedef struct packed {
        logic [1:0] status;
        t_rec       rec;
        logic       last;
    } t_emit;

endpackage

`default_nettype wire

/* rtl/stkthr_mem.sv */
// Record store of the stack: one write port, one registered read port.
// Depends on stkthr_pkg for the record type.
`default_nettype none

module stkthr_mem
    import stkthr_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_rec          i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_rec               o_rd_data
);

    t_rec r_mem [DEPTH];
    t_rec r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* rtl/stkthr_outreg.sv */
// Output register of the stack: one result slot toward the receiver.
// Depends on stkthr_pkg for the result type.
`default_nettype none

module stkthr_outreg
    import stkthr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_load,
    input  wire t_emit i_emit,
    input  wire logic  i_out_ready,
    output logic       o_valid,
    output t_emit      o_emit,
    output logic       o_free
);

    logic  r_valid;
    logic  n_valid;
    t_emit r_emit;

    // Slot can take a new result when empty or being drained this cycle
    assign o_free  = !r_valid || i_out_ready;
    assign n_valid = i_load || (r_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_emit <= i_emit;
        end
    end

    assign o_valid = r_valid;
    assign o_emit  = r_emit;

endmodule

`default_nettype wire

/* rtl/stack_threshold_remove.sv */
// Top level of the bounded record stack with threshold removal and drain.
// Depends on stkthr_pkg, stkthr_mem and stkthr_outreg.
//
// Usage:
//   Input channel i_in_valid / o_in_ready carries one request: opcode, name
//   tag, kind code, value (for push) and threshold (for remove-below).
//   Output channel o_out_valid / i_out_ready carries results: status,
//   record fields and o_last, which marks the final result of a request.
//   Requests are taken only while the sequencer is idle; a result waiting
//   in the output register does not block acceptance.
// Operation (memory reads are registered):
//   push            back-to-back pushes every cycle while the stack has room
//   pop / peek      read on acceptance, loaded in S_PEEK when the slot is free
//   error result    loaded in S_ERR when the slot is free
//   drain           one record per cycle from the top while the slot is free
//   remove-below    scan from the top, flush, then bottom-up compaction of
//                   the survivors (only when something matched)
// Reset empties the stack and the output slot; stored records need none.
// When the receiver stalls, the sequencer holds at the next record to emit
// and resumes as the slot frees; no result is dropped or repeated.
`default_nettype none

module stack_threshold_remove
    import stkthr_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic        [2:0]  i_opcode,
    input  wire logic        [31:0] i_name_tag,
    input  wire logic        [7:0]  i_kind_code,
    input  wire logic signed [31:0] i_item_value,
    input  wire logic signed [31:0] i_threshold,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic             [1:0]  o_status,
    output logic             [31:0] o_out_name,
    output logic             [7:0]  o_out_kind,
    output logic signed      [31:0] o_out_value,
    output logic                    o_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ERR   = 3'd1;
    localparam logic [2:0] S_PEEK  = 3'd2;
    localparam logic [2:0] S_DR_EV = 3'd3;
    localparam logic [2:0] S_RM_EV = 3'd4;
    localparam logic [2:0] S_RM_FL = 3'd5;
    localparam logic [2:0] S_CP_EV = 3'd6;

    logic [2:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_idx, n_idx;
    logic [AW-1:0]      r_wptr, n_wptr;
    logic signed [31:0] r_thr, n_thr;
    logic               r_pop, n_pop;
    logic [1:0]         r_err, n_err;
    t_rec               r_pend, n_pend;
    logic               r_pend_v, n_pend_v;

    logic          s_accept;
    logic [CW-1:0] s_top;
    logic          s_full;
    logic          s_match;
    logic          s_at_top;

    logic          s_wr_en;
    logic [AW-1:0] s_wr_addr;
    t_rec          s_wr_data;
    logic          s_rd_en;
    logic [AW-1:0] s_rd_addr;
    t_rec          s_rd_data;

    logic          s_load;
    t_emit         s_emit;
    t_emit         s_out_emit;
    logic          s_free;

    t_rec          s_push_rec;

    stkthr_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (s_wr_en),
        .i_wr_addr (s_wr_addr),
        .i_wr_data (s_wr_data),
        .i_rd_en   (s_rd_en),
        .i_rd_addr (s_rd_addr),
        .o_rd_data (s_rd_data)
    );

    stkthr_outreg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (s_load),
        .i_emit      (s_emit),
        .i_out_ready (i_out_ready),
        .o_valid     (o_out_valid),
        .o_emit      (s_out_emit),
        .o_free      (s_free)
    );

    assign o_status    = s_out_emit.status;
    assign o_out_name  = s_out_emit.rec.name;
    assign o_out_kind  = s_out_emit.rec.kind;
    assign o_out_value = s_out_emit.rec.value;
    assign o_last      = s_out_emit.last;

    assign o_in_ready = (r_state == S_IDLE);
    assign s_accept   = i_in_valid && o_in_ready;
    assign s_top      = r_count - CW'(1);
    assign s_full     = (r_count == CW'(DEPTH));
    assign s_match    = (s_rd_data.value < r_thr);
    assign s_at_top   = (CW'(r_idx) == s_top);

    assign s_push_rec.name  = i_name_tag;
    assign s_push_rec.kind  = i_kind_code;
    assign s_push_rec.value = i_item_value;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_wptr    = r_wptr;
        n_thr     = r_thr;
        n_pop     = r_pop;
        n_err     = r_err;
        n_pend    = r_pend;
        n_pend_v  = r_pend_v;
        s_wr_en   = 1'b0;
        s_wr_addr = r_wptr;
        s_wr_data = s_rd_data;
        s_rd_en   = 1'b0;
        s_rd_addr = s_top[AW-1:0];
        s_load    = 1'b0;
        s_emit    = '0;

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    case (i_opcode)
                        OP_PUSH: begin
                            if (s_full) begin
                                n_err   = ST_FULL;
                                n_state = S_ERR;
                            end else begin
                                s_wr_en   = 1'b1;
                                s_wr_addr = r_count[AW-1:0];
                                s_wr_data = s_push_rec;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        OP_POP, OP_PEEK: begin
                            if (r_count == '0) begin
                                n_err   = ST_EMPTY;
                                n_state = S_ERR;
                            end else begin
                                s_rd_en = 1'b1;
                                n_pop   = (i_opcode == OP_POP);
                                n_state = S_PEEK;
                            end
                        end
                        OP_REMOVE: begin
                            n_thr = i_threshold;
                            if (r_count != '0) begin
                                s_rd_en  = 1'b1;
                                n_idx    = s_top[AW-1:0];
                                n_pend_v = 1'b0;
                                n_state  = S_RM_EV;
                            end
                        end
                        OP_DRAIN: begin
                            if (r_count != '0) begin
                                s_rd_en = 1'b1;
                                n_idx   = s_top[AW-1:0];
                                n_state = S_DR_EV;
                            end
                        end
                        default: begin
                            // unused opcodes: drop the request
                        end
                    endcase
                end
            end

            S_ERR: begin
                if (s_free) begin
                    s_load        = 1'b1;
                    s_emit.status = r_err;
                    s_emit.last   = 1'b1;
                    n_state       = S_IDLE;
                end
            end

            S_PEEK: begin
                if (s_free) begin
                    s_load        = 1'b1;
                    s_emit.status = ST_OK;
                    s_emit.rec    = s_rd_data;
                    s_emit.last   = 1'b1;
                    if (r_pop) begin
                        n_count = s_top;
                    end
                    n_state = S_IDLE;
                end
            end

            S_DR_EV: begin
                if (s_free) begin
                    s_load        = 1'b1;
                    s_emit.status = ST_OK;
                    s_emit.rec    = s_rd_data;
                    s_emit.last   = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_count = '0;
                        n_state = S_IDLE;
                    end else begin
                        s_rd_en   = 1'b1;
                        s_rd_addr = r_idx - AW'(1);
                        n_idx     = r_idx - AW'(1);
                    end
                end
            end

            S_RM_EV: begin
                // Keep the newest match pending so the lowest one carries last
                if (!(s_match && r_pend_v && !s_free)) begin
                    if (s_match && r_pend_v) begin
                        s_load        = 1'b1;
                        s_emit.status = ST_OK;
                        s_emit.rec    = r_pend;
                    end
                    if (s_match) begin
                        n_pend   = s_rd_data;
                        n_pend_v = 1'b1;
                    end
                    if (r_idx == '0) begin
                        n_state = S_RM_FL;
                    end else begin
                        s_rd_en   = 1'b1;
                        s_rd_addr = r_idx - AW'(1);
                        n_idx     = r_idx - AW'(1);
                    end
                end
            end

            S_RM_FL: begin
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (s_free) begin
                    s_load        = 1'b1;
                    s_emit.status = ST_OK;
                    s_emit.rec    = r_pend;
                    s_emit.last   = 1'b1;
                    s_rd_en       = 1'b1;
                    s_rd_addr     = '0;
                    n_idx         = '0;
                    n_wptr        = '0;
                    n_state       = S_CP_EV;
                end
            end

            S_CP_EV: begin
                // Compact survivors downward; write slot never passes the read slot
                s_wr_en = !s_match;
                if (s_at_top) begin
                    n_count = CW'(r_wptr) + CW'(!s_match);
                    n_state = S_IDLE;
                end else begin
                    s_rd_en   = 1'b1;
                    s_rd_addr = r_idx + AW'(1);
                    n_idx     = r_idx + AW'(1);
                    n_wptr    = r_wptr + AW'(!s_match);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_wptr <= n_wptr;
        r_thr  <= n_thr;
        r_pop  <= n_pop;
        r_err  <= n_err;
        r_pend <= n_pend;
    end

    // Stack fill never exceeds its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    // A push into a stack with room grows it by one
    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_opcode == OP_PUSH && !s_full) |=> r_count == $past(r_count) + CW'(1))
        else $error("push did not grow the stack");

    // The final drained record leaves the stack empty
    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DR_EV && s_load && s_emit.last) |=> r_count == '0)
        else $error("drain left entries");

    // Compaction never writes above the slot being read
    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CP_EV) |-> r_wptr <= r_idx)
        else $error("compaction write pointer passed read pointer");

    // A result is loaded only into a free output slot
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_load |-> s_free)
        else $error("result loaded into an occupied slot");

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking bench for stack_threshold_remove: random and directed stack requests,
// a reference stack kept in the bench, and field-by-field checks of every result.
// Depends on stkthr_pkg and the stack_threshold_remove RTL.
`timescale 1ns / 100ps

module testbench;
    import stkthr_pkg::*;

    localparam int STACK_DEPTH = 64;
    localparam int CLK_HALF    = 6;
    // Opcodes the block ignores
    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD7 = 3'd7;
    // Longest walk of the block: remove-below scans, flushes and compacts
    localparam int DRAIN_CYCLES = 2 * STACK_DEPTH + 20;
    // Receiver hold-off that backs the block up against its input
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AT      = 30;
    // Requests to queue at the least
    localparam int N_REQS       = 310;

    // One request as offered on the input channel, plus the idle time after it
    typedef struct packed {
        logic        [2:0]  op;
        logic        [31:0] name;
        logic        [7:0]  kind;
        logic signed [31:0] value;
        logic signed [31:0] thr;
        logic        [3:0]  gap_after;
    } t_stack_req;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid  = 1'b0;
    logic        out_ready = 1'b0;
    t_stack_req  cur       = '0;

    wire         o_in_ready;
    wire         o_out_valid;
    wire  [1:0]  o_status;
    wire  [31:0] o_out_name;
    wire  [7:0]  o_out_kind;
    wire  [31:0] o_out_value;
    wire         o_last;

    t_stack_req  pending_reqs[$];
    t_emit       pending_emits[$];

    // Bench copy of the stack
    t_rec        stk_recs[STACK_DEPTH];
    int          stk_count = 0;

    int          n_total    = 0;
    int          n_accepted = 0;
    int          rx_count   = 0;
    int          fail_cnt   = 0;
    int          gap_left   = 0;
    int          rx_wait    = 0;
    bit          long_hold_done = 1'b0;

    stack_threshold_remove #(
        .DEPTH(STACK_DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (cur.op),
        .i_name_tag  (cur.name),
        .i_kind_code (cur.kind),
        .i_item_value(cur.value),
        .i_threshold (cur.thr),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_status    (o_status),
        .o_out_name  (o_out_name),
        .o_out_kind  (o_out_kind),
        .o_out_value (o_out_value),
        .o_last      (o_last)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Apply one accepted request to the bench stack and queue the results it causes.
    task automatic predict_stack_op(input t_stack_req r);
        t_emit batch[$];
        t_emit e;
        int    w;
        e = '0;
        case (r.op)
            OP_PUSH: begin
                if (stk_count >= STACK_DEPTH) begin
                    e.status = ST_FULL;
                    batch.push_back(e);
                end else begin
                    stk_recs[stk_count] = '{name: r.name, kind: r.kind, value: r.value};
                    stk_count++;
                end
            end
            OP_POP, OP_PEEK: begin
                if (stk_count == 0) begin
                    e.status = ST_EMPTY;
                end else begin
                    e.status = ST_OK;
                    e.rec    = stk_recs[stk_count - 1];
                    if (r.op == OP_POP)
                        stk_count--;
                end
                batch.push_back(e);
            end
            OP_REMOVE: begin
                // Emit matches from the top down, then close the gaps bottom-up
                for (int i = stk_count - 1; i >= 0; i--) begin
                    if ($signed(stk_recs[i].value) < $signed(r.thr)) begin
                        e.status = ST_OK;
                        e.rec    = stk_recs[i];
                        batch.push_back(e);
                    end
                end
                w = 0;
                for (int i = 0; i < stk_count; i++) begin
                    if (!($signed(stk_recs[i].value) < $signed(r.thr))) begin
                        stk_recs[w] = stk_recs[i];
                        w++;
                    end
                end
                stk_count = w;
            end
            OP_DRAIN: begin
                for (int i = stk_count - 1; i >= 0; i--) begin
                    e.status = ST_OK;
                    e.rec    = stk_recs[i];
                    batch.push_back(e);
                end
                stk_count = 0;
            end
            default: ;
        endcase
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            pending_emits.push_back(batch[i]);
    endtask

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%h, actual 0x%h", field, want, got);
            fail_cnt++;
        end
    endfunction

    // Mix of small values around zero, the two extremes and full-range noise
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'($signed($urandom_range(0, 16)) - 8);
            1:       return 32'h7fff_ffff;
            2:       return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Queue one request; the idle time after it depends on where it falls in the run
    task automatic queue_request(input logic [2:0] op, input logic [31:0] name,
                                 input logic [7:0] kind, input logic [31:0] value,
                                 input logic [31:0] thr);
        t_stack_req r;
        r.op    = op;
        r.name  = name;
        r.kind  = kind;
        r.value = value;
        r.thr   = thr;
        case ((pending_reqs.size() / 40) % 3)
            0:       r.gap_after = 4'd0;
            1:       r.gap_after = ($urandom_range(0, 9) < 3) ? 4'($urandom_range(1, 13)) : 4'd0;
            default: r.gap_after = 4'($urandom_range(0, 13));
        endcase
        pending_reqs.push_back(r);
    endtask

    // Driver: offer requests from the queue, hold each until accepted, then idle as drawn.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else if (in_valid && o_in_ready) begin
            predict_stack_op(cur);
            n_accepted++;
            if (cur.gap_after == 0 && pending_reqs.size() > 0) begin
                // advance straight to the next request, valid stays high
                cur <= pending_reqs.pop_front();
            end else begin
                in_valid <= 1'b0;
                gap_left <= (cur.gap_after > 0) ? int'(cur.gap_after) - 1 : 0;
            end
        end else if (!in_valid) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (pending_reqs.size() > 0) begin
                cur      <= pending_reqs.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    // Monitor and receiver: check each result against the oldest expectation, then stall
    // as drawn. Once, hold off for a long stretch so the block stalls its input.
    always @(posedge i_clk) begin : rx_side
        t_emit want;
        int    w;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            rx_wait   <= 0;
        end else if (o_out_valid && out_ready) begin
            if (pending_emits.size() == 0) begin
                $error("result with no request waiting: status %0d name 0x%h",
                       o_status, o_out_name);
                fail_cnt++;
            end else begin
                want = pending_emits.pop_front();
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("out_name", want.rec.name, o_out_name);
                check_field("out_kind", 32'(want.rec.kind), 32'(o_out_kind));
                check_field("out_value", want.rec.value, o_out_value);
                check_field("last", 32'(want.last), 32'(o_last));
            end
            rx_count++;
            if (rx_count == HOLD_AT && !long_hold_done) begin
                long_hold_done = 1'b1;
                out_ready <= 1'b0;
                rx_wait   <= LONG_HOLD;
            end else begin
                case ((rx_count / 40) % 3)
                    0:       w = 0;
                    1:       w = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 13) : 0;
                    default: w = $urandom_range(0, 13);
                endcase
                if (w > 0) begin
                    out_ready <= 1'b0;
                    rx_wait   <= w - 1;
                end
            end
        end else if (!out_ready) begin
            if (rx_wait > 0)
                rx_wait <= rx_wait - 1;
            else
                out_ready <= 1'b1;
        end
    end

    initial begin : stimulus
        int iter;
        int pick;

        // Directed: empty-stack errors, ignored opcodes, field extremes, filtering
        queue_request(OP_POP,    32'h0, 8'h0, 32'h0, 32'h0);
        queue_request(OP_PEEK,   32'h0, 8'h0, 32'h0, 32'h0);
        queue_request(OP_DRAIN,  32'h0, 8'h0, 32'h0, 32'h0);
        queue_request(OP_REMOVE, 32'h0, 8'h0, 32'h0, 32'h7fff_ffff);
        for (int op = OP_RSVD5; op <= OP_RSVD7; op++)
            queue_request(3'(op), 32'hffff_ffff, 8'hff, 32'h7fff_ffff, 32'h7fff_ffff);
        queue_request(OP_PUSH,   32'hffff_ffff, 8'hff, 32'h7fff_ffff, 32'h0);
        queue_request(OP_PUSH,   32'h0000_0000, 8'h00, 32'h8000_0000, 32'h0);
        queue_request(OP_PUSH,   32'ha5a5_a5a5, 8'h5a, 32'hffff_ffff, 32'h0);
        queue_request(OP_PUSH,   32'h5a5a_5a5a, 8'ha5, 32'h0000_0000, 32'h0);
        queue_request(OP_PEEK,   32'h0, 8'h0, 32'h0, 32'h0);
        // nothing lies below the minimum
        queue_request(OP_REMOVE, 32'h0, 8'h0, 32'h0, 32'h8000_0000);
        // drop the two negatives; survivors keep their order
        queue_request(OP_REMOVE, 32'h0, 8'h0, 32'h0, 32'h0000_0000);
        queue_request(OP_POP,    32'h0, 8'h0, 32'h0, 32'h0);
        queue_request(OP_PUSH,   32'h1234_5678, 8'h33, 32'h1, 32'h0);
        queue_request(OP_PUSH,   32'h8765_4321, 8'hcc, 32'h2, 32'h0);
        // everything below the maximum goes, the maximum stays
        queue_request(OP_REMOVE, 32'h0, 8'h0, 32'h0, 32'h7fff_ffff);
        queue_request(OP_POP,    32'h0, 8'h0, 32'h0, 32'h0);
        queue_request(OP_POP,    32'h0, 8'h0, 32'h0, 32'h0);
        queue_request(OP_PUSH,   32'hdead_0001, 8'h7e, 32'hffff_fff0, 32'h0);
        queue_request(OP_DRAIN,  32'h0, 8'h0, 32'h0, 32'h0);

        // Random: short mixed bursts, and now and then a fill to full and past it
        iter = 0;
        while (pending_reqs.size() < N_REQS) begin
            if ((iter == 2 || iter == 9 || $urandom_range(0, 19) == 0) &&
                pending_reqs.size() + STACK_DEPTH + 6 <= N_REQS) begin
                queue_request(OP_DRAIN, $urandom(), 8'($urandom()), pick_value(), pick_value());
                repeat (STACK_DEPTH + 2)
                    queue_request(OP_PUSH, $urandom(), 8'($urandom_range(0, 255)),
                                  pick_value(), pick_value());
                if ($urandom_range(0, 1) == 0) begin
                    queue_request(OP_DRAIN, $urandom(), 8'($urandom()), pick_value(),
                                  pick_value());
                end else begin
                    queue_request(OP_REMOVE, $urandom(), 8'($urandom()), pick_value(),
                                  pick_value());
                    repeat (3)
                        queue_request(OP_POP, $urandom(), 8'($urandom()), pick_value(),
                                      pick_value());
                end
            end else begin
                repeat (10) begin
                    pick = $urandom_range(0, 19);
                    if (pick <= 8 || pick >= 18)
                        queue_request(OP_PUSH, $urandom(), 8'($urandom_range(0, 255)),
                                      pick_value(), pick_value());
                    else if (pick <= 11)
                        queue_request(OP_POP, $urandom(), 8'($urandom()), pick_value(),
                                      pick_value());
                    else if (pick <= 13)
                        queue_request(OP_PEEK, $urandom(), 8'($urandom()), pick_value(),
                                      pick_value());
                    else if (pick <= 15)
                        queue_request(OP_REMOVE, $urandom(), 8'($urandom()), pick_value(),
                                      pick_value());
                    else if (pick == 16)
                        queue_request(OP_DRAIN, $urandom(), 8'($urandom()), pick_value(),
                                      pick_value());
                    else
                        queue_request(3'($urandom_range(OP_RSVD5, OP_RSVD7)), $urandom(),
                                      8'($urandom()), pick_value(), pick_value());
                end
            end
            iter++;
        end
        n_total = pending_reqs.size();

        // Hold reset, then release it for good
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to go in and every result to come out
        do
            @(negedge i_clk);
        while (n_accepted < n_total || pending_emits.size() > 0);
        // Let a trailing walk finish and catch any stray result
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_cnt == 0 && pending_emits.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
